### rtl/lfu_pkg.sv
package lfu_pkg;

  // Built table depth and play count width.
  localparam int ENTRIES   = 8;
  localparam int HIT_BITS  = 16;

  // Fixed field widths.
  localparam int KEY_W     = 31;
  localparam int STAMP_W   = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int CAP_W     = 4;
  localparam int CAP_RESET = 8;

  // Derived widths: an entry index and an occupancy count that can hold ENTRIES.
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_PLAY   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_ADDED     = 3'd0,
    RS_EVICTED   = 3'd1,
    RS_PRESENT   = 3'd2,
    RS_PLAYED    = 3'd3,
    RS_NOT_FOUND = 3'd4,
    RS_DELETED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             start;
    logic             step;
    logic [IDX_W-1:0] idx;
    logic             commit;
  } lfu_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;
  } lfu_stat_t;

endpackage

### rtl/lfu_ctrl.sv
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lfu_stat_t stat,
  output lfu_cmd_t  cmd
);

  ctrl_state_t      state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          idx_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (idx == IDX_W'(ENTRIES - 1)) begin
          state_next = S_APPLY;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_APPLY: begin
        // Hold here until the output register can take the result.
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/lfu_datapath.sv
module lfu_datapath
  import lfu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata,
  input  logic [OP_W-1:0]     opcode,
  input  logic [KEY_W-1:0]    song_id,
  input  lfu_cmd_t            cmd,
  output lfu_stat_t           stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    evicted_id
);

  // Table storage. Only valid bits, the order counter, occupancy and capacity are reset.
  logic [ENTRIES-1:0]  entry_valid;
  logic [KEY_W-1:0]    entry_key   [ENTRIES];
  logic [HIT_BITS-1:0] entry_hits  [ENTRIES];
  logic [STAMP_W-1:0]  entry_stamp [ENTRIES];
  logic [STAMP_W-1:0]  seq;
  logic [CNT_W-1:0]    occ;
  logic [CAP_W-1:0]    cap;

  // Request and scan results.
  op_t                 req_op;
  logic [KEY_W-1:0]    req_key;
  logic                match_found;
  logic [IDX_W-1:0]    match_idx;
  logic [HIT_BITS-1:0] match_hits;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic                vic_found;
  logic [IDX_W-1:0]    vic_idx;
  logic [HIT_BITS-1:0] vic_hits;
  logic [STAMP_W-1:0]  vic_age;
  logic [KEY_W-1:0]    vic_key;

  // Scan of the entry at cmd.idx.
  logic                e_valid;
  logic [KEY_W-1:0]    e_key;
  logic [HIT_BITS-1:0] e_hits;
  logic [STAMP_W-1:0]  e_age;
  logic                e_match;
  logic                e_better;

  assign e_valid  = entry_valid[cmd.idx];
  assign e_key    = entry_key[cmd.idx];
  assign e_hits   = entry_hits[cmd.idx];
  assign e_age    = seq - entry_stamp[cmd.idx];
  assign e_match  = e_valid && (e_key == req_key);
  assign e_better = !vic_found || (e_hits < vic_hits) ||
                    ((e_hits == vic_hits) && (e_age > vic_age));

  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      vic_found   <= 1'b0;
    end else if (cmd.start) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      vic_found   <= 1'b0;
    end else if (cmd.step) begin
      if (e_match && !match_found) begin
        match_found <= 1'b1;
      end
      if (!e_valid && !free_found) begin
        free_found <= 1'b1;
      end
      if (e_valid && e_better) begin
        vic_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op  <= op_t'(opcode);
      req_key <= song_id;
    end
    if (cmd.step) begin
      if (e_match && !match_found) begin
        match_idx  <= cmd.idx;
        match_hits <= e_hits;
      end
      if (!e_valid && !free_found) begin
        free_idx <= cmd.idx;
      end
      if (e_valid && e_better) begin
        vic_idx  <= cmd.idx;
        vic_hits <= e_hits;
        vic_age  <= e_age;
        vic_key  <= e_key;
      end
    end
  end

  // Effective capacity: zero counts as one, anything above the depth as the depth.
  logic [CNT_W-1:0] lim;
  logic             full;

  always_comb begin
    if (cap == '0) begin
      lim = CNT_W'(1);
    end else if (int'(cap) > ENTRIES) begin
      lim = CNT_W'(ENTRIES);
    end else begin
      lim = CNT_W'(cap);
    end
  end

  assign full = (occ >= lim);

  // Result and table update for the request.
  status_t             res_status;
  logic [KEY_W-1:0]    res_evict;
  logic [IDX_W-1:0]    wr_idx;
  logic                key_we;
  logic                hits_we;
  logic [HIT_BITS-1:0] hits_val;
  logic                stamp_we;
  logic                set_valid;
  logic                clr_valid;
  logic                occ_inc;
  logic                occ_dec;

  always_comb begin
    res_status = RS_NOT_FOUND;
    res_evict  = '0;
    wr_idx     = match_idx;
    key_we     = 1'b0;
    hits_we    = 1'b0;
    hits_val   = '0;
    stamp_we   = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    occ_inc    = 1'b0;
    occ_dec    = 1'b0;
    case (req_op)
      OP_ADD: begin
        if (match_found) begin
          res_status = RS_PRESENT;
        end else if (full && vic_found) begin
          res_status = RS_EVICTED;
          res_evict  = vic_key;
          wr_idx     = vic_idx;
          key_we     = 1'b1;
          hits_we    = 1'b1;
          stamp_we   = 1'b1;
          set_valid  = 1'b1;
        end else begin
          res_status = RS_ADDED;
          if (free_found) begin
            wr_idx    = free_idx;
            key_we    = 1'b1;
            hits_we   = 1'b1;
            stamp_we  = 1'b1;
            set_valid = 1'b1;
            occ_inc   = 1'b1;
          end
        end
      end
      OP_PLAY: begin
        if (match_found) begin
          res_status = RS_PLAYED;
          // A saturated count keeps both count and stamp.
          if (match_hits != {HIT_BITS{1'b1}}) begin
            hits_we  = 1'b1;
            hits_val = match_hits + 1'b1;
            stamp_we = (match_hits == '0);
          end
        end
      end
      OP_DELETE: begin
        if (match_found) begin
          res_status = RS_DELETED;
          clr_valid  = 1'b1;
          occ_dec    = (occ != '0);
        end
      end
      default: begin
        res_status = RS_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      seq         <= '0;
      occ         <= '0;
      cap         <= CAP_W'(CAP_RESET);
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (cmd.commit) begin
        if (set_valid) begin
          entry_valid[wr_idx] <= 1'b1;
        end
        if (clr_valid) begin
          entry_valid[wr_idx] <= 1'b0;
        end
        if (stamp_we) begin
          seq <= seq + 1'b1;
        end
        if (occ_inc) begin
          occ <= occ + 1'b1;
        end else if (occ_dec) begin
          occ <= occ - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (key_we) begin
        entry_key[wr_idx] <= req_key;
      end
      if (hits_we) begin
        entry_hits[wr_idx] <= hits_val;
      end
      if (stamp_we) begin
        entry_stamp[wr_idx] <= seq;
      end
    end
  end

  // Output register.
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= res_status;
      evicted_id <= res_evict;
    end
  end

`ifndef SYNTHESIS
  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    int'(occ) == $countones(entry_valid))
    else $error("occupancy count differs from the number of valid entries");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("result committed while the output register is still full");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result did not reach the output");

  a_evict_id_only_on_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != RS_EVICTED)) |-> (evicted_id == '0))
    else $error("evicted id is nonzero on a result without eviction");
`endif

endmodule

### rtl/lfu_table_with_eviction_top.sv
// LFU table with eviction: a keyed table of up to eight entries that replaces
// the least-played entry when an add finds the table full.
// The request channel (in_valid, in_ready, opcode, song_id) moves one beat per
// request: add, play or delete of an id. The response channel (out_valid,
// out_ready, status, evicted_id) returns exactly one beat per request, in order.
// The user must write the capacity register through cfg_we and cfg_wdata only
// while the block is idle, which is not enforced; it takes effect on the next request.
// Each request is captured in the idle state; the datapath then walks the table
// one entry per cycle through all eight entries looking for the key, the first
// free slot and the eviction victim, and an update step writes the table and
// loads the response register. A new request is taken only after the previous
// one has left the update step.
// The response sits in an output register, so the next request is accepted and
// scanned while an earlier response still waits; if the receiver stalls, the
// block holds in its update step until that register frees up.
// Synchronous reset empties the table, clears the order counter and occupancy,
// and sets the capacity to eight.
module lfu_table_with_eviction_top
  import lfu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     opcode,
  input  logic [KEY_W-1:0]    song_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    evicted_id
);

  // Command and status bundles between the sequencer and the table datapath.
  lfu_cmd_t  cmd;
  lfu_stat_t stat;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfu_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .opcode     (opcode),
    .song_id    (song_id),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .status     (status),
    .evicted_id (evicted_id)
  );

endmodule
